@@ rtl/core/epp_pkg.sv @@
`timescale 1ns / 1ps

package epp_pkg;

    // default number of encoder channels
    localparam int CHANNELS_DEF = 2;

    // configuration register indexes
    localparam logic [2:0] REG_DIST_PER_COUNT = 3'd0;
    localparam logic [2:0] REG_KP             = 3'd1;
    localparam logic [2:0] REG_KD             = 3'd2;
    localparam logic [2:0] REG_KI             = 3'd3;
    localparam logic [2:0] REG_DUTY_LIMIT     = 3'd4;
    localparam logic [2:0] REG_ARRIVE_BAND    = 3'd5;

    // integrate only below 100.0, clamp integral to +-10000.0 (q16.16)
    localparam logic signed [31:0] INT_GATE  = 32'sd6553600;
    localparam logic signed [31:0] INT_CLAMP = 32'sd655360000;

    // one command per processing step
    typedef struct packed {
        logic load_in;
        logic mul_step;
        logic dist_upd;
        logic err;
        logic integ;
        logic mul_d;
        logic mul_i;
        logic fin;
    } t_cmd;

    // saturate a wide signed value to the signed 32-bit range
    function automatic logic signed [31:0] f_sat32(input logic signed [49:0] v);
        logic signed [49:0] hi;
        logic signed [49:0] lo;
        hi = 50'sd2147483647;
        lo = -50'sd2147483648;
        if (v > hi) begin
            return 32'sh7fffffff;
        end else if (v < lo) begin
            return 32'sh80000000;
        end else begin
            return v[31:0];
        end
    endfunction

endpackage

@@ rtl/core/epp_ctrl.sv @@
`timescale 1ns / 1ps

module epp_ctrl (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_in_valid,
    output logic          o_in_ready,
    output logic          o_out_valid,
    input  logic          i_out_ready,
    output epp_pkg::t_cmd o_cmd
);

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_MSTEP = 8'b0000_0010,
        S_DIST  = 8'b0000_0100,
        S_ERR   = 8'b0000_1000,
        S_INTEG = 8'b0001_0000,
        S_MULD  = 8'b0010_0000,
        S_MULI  = 8'b0100_0000,
        S_FIN   = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_MSTEP;
                end
            end
            S_MSTEP: begin
                o_cmd.mul_step = 1'b1;
                n_state        = S_DIST;
            end
            S_DIST: begin
                o_cmd.dist_upd = 1'b1;
                n_state        = S_ERR;
            end
            S_ERR: begin
                o_cmd.err = 1'b1;
                n_state   = S_INTEG;
            end
            S_INTEG: begin
                o_cmd.integ = 1'b1;
                n_state     = S_MULD;
            end
            S_MULD: begin
                o_cmd.mul_d = 1'b1;
                n_state     = S_MULI;
            end
            S_MULI: begin
                o_cmd.mul_i = 1'b1;
                n_state     = S_FIN;
            end
            S_FIN: begin
                // wait until the result slot is free
                if (!r_out_valid || i_out_ready) begin
                    o_cmd.fin = 1'b1;
                    n_state   = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (o_cmd.fin) begin
            n_out_valid = 1'b1;
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

endmodule

@@ rtl/core/epp_dp.sv @@
`timescale 1ns / 1ps

module epp_dp #(
    parameter int CHANNELS = epp_pkg::CHANNELS_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  epp_pkg::t_cmd       i_cmd,
    input  logic                i_channel,
    input  logic signed [31:0]  i_target,
    input  logic [15:0]         i_count_now,
    input  logic                i_cfg_we,
    input  logic [2:0]          i_cfg_index,
    input  logic [31:0]         i_cfg_data,
    output logic signed [31:0]  o_duty,
    output logic                o_done_res
);

    localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

    // configuration
    logic signed [31:0] r_dpc, r_kp, r_kd, r_ki;
    logic [30:0]        r_limit, r_band_cfg;

    // per-channel state
    logic [15:0]        r_last  [CHANNELS];
    logic signed [31:0] r_dist  [CHANNELS];
    logic signed [31:0] r_prev  [CHANNELS];
    logic signed [31:0] r_ist   [CHANNELS];

    // item registers
    logic [CH_W-1:0]    r_ch;
    logic               r_oor;
    logic signed [31:0] r_target;
    logic [15:0]        r_cnt;
    logic signed [63:0] r_prod;
    logic signed [31:0] r_dnew;
    logic signed [31:0] r_err, r_derr;
    logic signed [31:0] r_integ;
    logic               r_band;
    logic signed [49:0] r_acc;
    logic signed [31:0] r_duty;
    logic               r_done;

    // shared multiplier operands
    logic [15:0]        w_step;
    logic signed [31:0] w_ma, w_mb;
    logic               w_mul_en;

    logic signed [47:0] w_pstep;
    logic signed [47:0] w_pshift;
    logic signed [49:0] w_dsum;
    logic signed [49:0] w_esum, w_dersum;
    logic signed [32:0] w_isum, w_inext;
    logic signed [31:0] w_iclamp;
    logic signed [32:0] w_e33;
    logic [32:0]        w_mag;
    logic               w_inband;
    logic signed [49:0] w_total, w_lim;
    logic signed [31:0] w_dclamp;

    assign w_step   = r_cnt - r_last[r_ch];
    assign w_mul_en = i_cmd.mul_step | i_cmd.integ | i_cmd.mul_d | i_cmd.mul_i;

    always_comb begin
        w_ma = 32'(signed'(w_step));
        w_mb = r_dpc;
        if (i_cmd.integ) begin
            w_ma = r_err;
            w_mb = r_kp;
        end else if (i_cmd.mul_d) begin
            w_ma = r_derr;
            w_mb = r_kd;
        end else if (i_cmd.mul_i) begin
            w_ma = r_integ;
            w_mb = r_ki;
        end
    end

    // distance update with saturation
    assign w_pstep = r_prod[47:0];
    assign w_dsum  = 50'(r_dist[r_ch]) + 50'(w_pstep);

    // error and derivative
    assign w_esum   = 50'(r_target) - 50'(r_dnew);
    assign w_dersum = 50'(r_prev[r_ch]) - 50'(r_dnew);

    // gated, clamped integral
    assign w_isum  = 33'(r_ist[r_ch]) + 33'(r_err);
    assign w_inext = (r_err < epp_pkg::INT_GATE) ? w_isum : 33'(r_ist[r_ch]);
    always_comb begin
        if (w_inext > 33'(epp_pkg::INT_CLAMP)) begin
            w_iclamp = epp_pkg::INT_CLAMP;
        end else if (w_inext < -33'(epp_pkg::INT_CLAMP)) begin
            w_iclamp = -epp_pkg::INT_CLAMP;
        end else begin
            w_iclamp = w_inext[31:0];
        end
    end

    // arrival band on |error|
    assign w_e33    = 33'(r_err);
    assign w_mag    = w_e33[32] ? unsigned'(-w_e33) : unsigned'(w_e33);
    assign w_inband = w_mag < {2'b00, r_band_cfg};

    // floor(product / 2^16) and duty clamp
    assign w_pshift = r_prod[63:16];
    assign w_total  = r_acc + 50'(w_pshift);
    assign w_lim    = signed'({19'b0, r_limit});
    always_comb begin
        if (w_total > w_lim) begin
            w_dclamp = signed'({1'b0, r_limit});
        end else if (w_total < -w_lim) begin
            w_dclamp = -signed'({1'b0, r_limit});
        end else begin
            w_dclamp = w_total[31:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dpc      <= '0;
            r_kp       <= '0;
            r_kd       <= '0;
            r_ki       <= '0;
            r_limit    <= '0;
            r_band_cfg <= '0;
            for (int i = 0; i < CHANNELS; i++) begin
                r_last[i] <= '0;
                r_dist[i] <= '0;
                r_prev[i] <= '0;
                r_ist[i]  <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    epp_pkg::REG_DIST_PER_COUNT: r_dpc      <= i_cfg_data;
                    epp_pkg::REG_KP:             r_kp       <= i_cfg_data;
                    epp_pkg::REG_KD:             r_kd       <= i_cfg_data;
                    epp_pkg::REG_KI:             r_ki       <= i_cfg_data;
                    epp_pkg::REG_DUTY_LIMIT:     r_limit    <= i_cfg_data[30:0];
                    epp_pkg::REG_ARRIVE_BAND:    r_band_cfg <= i_cfg_data[30:0];
                    default: begin
                    end
                endcase
            end
            if (i_cmd.err && !r_oor) begin
                r_last[r_ch] <= r_cnt;
                r_dist[r_ch] <= r_dnew;
                r_prev[r_ch] <= r_dnew;
            end
            if (i_cmd.integ && !r_oor) begin
                r_ist[r_ch] <= w_inband ? '0 : w_iclamp;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_ch     <= CH_W'(i_channel);
            r_oor    <= {31'b0, i_channel} >= 32'(CHANNELS);
            r_target <= i_target;
            r_cnt    <= i_count_now;
        end
        if (w_mul_en) begin
            r_prod <= w_ma * w_mb;
        end
        if (i_cmd.dist_upd) begin
            r_dnew <= epp_pkg::f_sat32(w_dsum);
        end
        if (i_cmd.err) begin
            r_err  <= epp_pkg::f_sat32(w_esum);
            r_derr <= epp_pkg::f_sat32(w_dersum);
        end
        if (i_cmd.integ) begin
            r_integ <= w_iclamp;
            r_band  <= w_inband;
        end
        if (i_cmd.mul_d) begin
            r_acc <= 50'(w_pshift);
        end
        if (i_cmd.mul_i) begin
            r_acc <= w_total;
        end
        if (i_cmd.fin) begin
            r_duty <= (r_oor || r_band) ? '0 : w_dclamp;
            r_done <= !r_oor && r_band;
        end
    end

    assign o_duty     = r_duty;
    assign o_done_res = r_done;

endmodule

@@ rtl/core/encoder_position_pid.sv @@
`timescale 1ns / 1ps

// position pid controller for quadrature-counted axes, q16.16 throughout.
// each input item names a channel, a target distance and the raw 16-bit
// counter of that channel; one result item (duty, done_res) comes back per
// item. an item occupies the block for one accept cycle and seven processing
// steps when the output is free, paced by the single shared 32x32 multiplier
// that forms the distance step and the p, d and i products in turn. the result
// is valid once the final step has loaded it into the output register.
// a new item is accepted once the previous one has moved
// into the output register, even while that result still waits to be taken.
// configuration writes go straight to the registers, are always accepted and
// must only happen while the block is idle.

module encoder_position_pid #(
    parameter int CHANNELS = epp_pkg::CHANNELS_DEF
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    // input items
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic               i_channel,
    input  logic signed [31:0] i_target,
    input  logic [15:0]        i_count_now,
    // result items
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic signed [31:0] o_duty,
    output logic               o_done_res,
    // configuration writes
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [2:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    epp_pkg::t_cmd w_cmd;

    // config port never stalls
    assign o_cfg_ready = 1'b1;

    // sequencer: one-hot state walk, one command per step
    epp_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_cmd       (w_cmd)
    );

    // datapath: config, per-channel state, shared multiplier, output register
    epp_dp #(
        .CHANNELS (CHANNELS)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_channel   (i_channel),
        .i_target    (i_target),
        .i_count_now (i_count_now),
        .i_cfg_we    (i_cfg_valid & o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_duty      (o_duty),
        .o_done_res  (o_done_res)
    );

    // an accepted item keeps the input closed for the processing steps
    a_busy_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> !o_in_ready)
        else $error("input ready right after accepting an item");

    // arrival always forces zero drive
    a_done_zero_duty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_done_res) |-> (o_duty == 32'sd0))
        else $error("done result with nonzero duty");

    // a fresh result only comes out of the final processing step
    a_result_after_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(o_out_valid) |-> !$past(o_in_ready))
        else $error("result appeared without processing");

endmodule
